FILE: hw/rtl/gxb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gxb_pkg
// Shared types, font table and constants for the glyph XOR blitter.
// ----------------------------------------------------------------------------
package gxb_pkg;

  localparam int unsigned FB_WIDTH_DEF  = 128;
  localparam int unsigned FB_HEIGHT_DEF = 64;

  localparam int unsigned GLYPH_ROWS = 6;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned FONT_SIZE  = 13;
  localparam int unsigned PEN_W      = 16;
  localparam int unsigned PEN_STEP   = 6;
  localparam int unsigned ROW_W      = 3;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  localparam logic [7:0] CODE_DIGIT_0 = 8'h30;
  localparam logic [7:0] CODE_DIGIT_9 = 8'h39;
  localparam logic [7:0] CODE_COMMA   = 8'h2C;
  localparam logic [7:0] CODE_M       = 8'h6D;
  localparam logic [7:0] CODE_S       = 8'h73;

  localparam logic [3:0] GLYPH_COMMA = 4'd10;
  localparam logic [3:0] GLYPH_M     = 4'd11;
  localparam logic [3:0] GLYPH_S     = 4'd12;
  localparam logic [3:0] GLYPH_ZERO  = 4'd0;

  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_t;

  localparam glyph_t FONT [0:FONT_SIZE-1] = '{
    '{5'h1F, 5'h11, 5'h15, 5'h15, 5'h11, 5'h1F},
    '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h1F, 5'h10, 5'h1F},
    '{5'h1F, 5'h01, 5'h1F, 5'h01, 5'h01, 5'h1F},
    '{5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1F, 5'h01, 5'h01, 5'h1F},
    '{5'h1F, 5'h10, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h01, 5'h01, 5'h01, 5'h01},
    '{5'h1F, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h1F},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h04},
    '{5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15},
    '{5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E}
  };

  typedef struct packed {
    logic [7:0] char_code;
    logic [6:0] text_x;
    logic [5:0] text_y;
    logic       first_char;
    logic       last_char;
  } req_t;

  typedef struct packed {
    logic [9:0]       byte_addr;
    logic [7:0]       xor_mask;
    logic [ROW_W-1:0] glyph_row;
    logic             last_write;
    logic             text_done;
  } cmd_t;

  typedef struct packed {
    glyph_t         rows;
    logic [2:0]     shift;
    logic [PEN_W-4:0] pen_byte;
    logic [5:0]     text_y;
    logic           last_char;
  } job_t;

  function automatic logic [3:0] glyph_index(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - CODE_DIGIT_0;
    priority if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9) return diff[3:0];
    else if (code == CODE_COMMA) return GLYPH_COMMA;
    else if (code == CODE_M)     return GLYPH_M;
    else if (code == CODE_S)     return GLYPH_S;
    else                         return GLYPH_ZERO;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/gxb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gxb_front
// Accepts character requests, tracks the pen column and looks up the glyph.
// ----------------------------------------------------------------------------
module gxb_front import gxb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  input  wire logic q_full,
  output logic      push,
  output job_t      job
);

  logic [PEN_W-1:0] pen;
  logic [PEN_W-1:0] pen_next;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;
  assign pen_next  = req.first_char ? PEN_W'(req.text_x) : pen;

  always_comb begin
    job.rows      = FONT[glyph_index(req.char_code)];
    job.shift     = pen_next[2:0];
    job.pen_byte  = pen_next[PEN_W-1:3];
    job.text_y    = req.text_y;
    job.last_char = req.last_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen <= '0;
    end else if (push) begin
      pen <= pen_next + PEN_W'(PEN_STEP);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gxb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gxb_queue
// Two-entry queue of decoded characters between front and back.
// ----------------------------------------------------------------------------
module gxb_queue import gxb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output job_t      head
);

  job_t       mem [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/gxb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gxb_back
// Walks the six glyph rows, two byte writes per row, into the output register.
// ----------------------------------------------------------------------------
module gxb_back import gxb_pkg::*; #(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_not_empty,
  input  wire job_t q_head,
  output logic      pop,
  output logic      cmd_valid,
  input  wire logic cmd_stall,
  output cmd_t      cmd
);

  localparam int unsigned RB       = FB_WIDTH / 8;
  localparam int unsigned FB_BYTES = RB * FB_HEIGHT;
  localparam int unsigned MAX_ADDR = (64 + GLYPH_ROWS) * RB + (1 << (PEN_W - 3));
  localparam int unsigned TOP_ADDR = (MAX_ADDR > FB_BYTES) ? MAX_ADDR : FB_BYTES;
  localparam int unsigned AW       = $clog2(TOP_ADDR + 1);

  logic             busy;
  logic [ROW_W-1:0] row;
  logic             half;
  logic [AW-1:0]    cur_addr;
  logic [AW-1:0]    row_base;
  glyph_t           rows;
  logic [2:0]       shift;
  logic             last_char;

  logic             advance;
  logic             in_range;
  logic             at_end;
  logic [AW-1:0]    row_step;
  logic [AW-1:0]    nxt_addr;
  logic             nxt_ok;
  logic             emit;
  logic             finish;
  logic [AW-1:0]    base0;
  logic [15:0]      spread;

  assign advance  = !cmd_valid || !cmd_stall;
  assign in_range = cur_addr < AW'(FB_BYTES);
  assign at_end   = (row == LAST_ROW) && half;
  assign row_step = row_base + AW'(RB);
  assign nxt_addr = half ? row_step : cur_addr + AW'(1);
  assign nxt_ok   = !at_end && (nxt_addr < AW'(FB_BYTES));
  assign emit     = busy && in_range && advance;
  assign finish   = busy && (!in_range || (advance && !nxt_ok));
  assign pop      = q_not_empty && (!busy || finish);
  assign base0    = AW'(q_head.text_y) * AW'(RB) + AW'(q_head.pen_byte);
  assign spread   = {3'b000, rows[row], 8'h00} >> shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (advance) cmd_valid <= emit;
      if (pop) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row       <= '0;
      half      <= 1'b0;
      cur_addr  <= base0;
      row_base  <= base0;
      rows      <= q_head.rows;
      shift     <= q_head.shift;
      last_char <= q_head.last_char;
    end else if (emit) begin
      if (half) begin
        row      <= row + ROW_W'(1);
        half     <= 1'b0;
        row_base <= row_step;
        cur_addr <= row_step;
      end else begin
        half     <= 1'b1;
        cur_addr <= cur_addr + AW'(1);
      end
    end
    if (emit) begin
      cmd.byte_addr  <= cur_addr[9:0];
      cmd.xor_mask   <= half ? spread[7:0] : spread[15:8];
      cmd.glyph_row  <= row;
      cmd.last_write <= !nxt_ok;
      cmd.text_done  <= !nxt_ok && last_char;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/glyph_xor_blitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_xor_blitter_unit
// Draws 5-wide, 6-row font glyphs into a 1bpp MSB-first framebuffer as XOR byte writes.
// ----------------------------------------------------------------------------
//  channel  handshake             payload  carries
//  req      req_valid/req_stall   req_t    one character of a string
//  cmd      cmd_valid/cmd_stall   cmd_t    one byte address plus XOR mask
//
//  Each character yields 12 writes, one per cycle at the cmd register while
//  cmd_stall is low; writes past the buffer end are dropped and shorten the
//  character's run. A character is written into the two-entry queue and then
//  loaded by the back end when it pops it. Reset clears the pen column, the
//  two-entry queue and the write sequencer. A cmd stall holds the write; once
//  the queue is full, req_stall rises.
// ----------------------------------------------------------------------------
module glyph_xor_blitter_unit import gxb_pkg::*; #(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      cmd_valid,
  input  wire logic cmd_stall,
  output cmd_t      cmd
);

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic q_not_empty;
  job_t q_head;

  gxb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  gxb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  gxb_back #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/gxb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gxb_checker
// Port-level checks on the blitter's write channel and reset behavior.
// ----------------------------------------------------------------------------
module gxb_checker import gxb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_stall,
  input wire logic cmd_valid,
  input wire logic cmd_stall,
  input wire cmd_t cmd
);

  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
    else $error("stalled write changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !cmd_valid && !req_stall)
    else $error("not idle after reset");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd.glyph_row <= LAST_ROW)
    else $error("glyph row out of range");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd.text_done |-> cmd.last_write)
    else $error("text done without last write");

endmodule

bind glyph_xor_blitter_unit gxb_checker u_gxb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd)
);
`default_nettype wire
